/* hdl/fte_pkg.sv */
// Package with the types and constants shared by the flow table modules.
`default_nettype none
package fte_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 96;
  localparam int VAL_W    = 192;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WB
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port_in;
    logic [15:0] dest_port_in;
    logic [63:0] flow_state_in;
    logic [63:0] stamp_in;
    logic [63:0] count_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] flow_state_out;
    logic [63:0] stamp_out;
    logic [63:0] count_out;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage
`default_nettype wire

/* hdl/flow_table_exact_match_unit.sv */
// Top level of the exact match flow table: controller plus datapath.
// Each item is accepted, then the key memory is scanned one entry per cycle
// through its single read port, then the last entry is compared and the result
// is written back; write back waits while an earlier result is held by out_stall.
// A new item is accepted only after the write back of the previous one.
// Reset clears all entry valid bits at once; no clearing pass is needed.
`default_nettype none
module flow_table_exact_match_unit
  import fte_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  fte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fte_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* hdl/fte_ctrl.sv */
// Controller state machine that sequences accept, key scan and write back.
`default_nettype none
module fte_ctrl
  import fte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_WB: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/fte_datapath.sv */
// Datapath with the key and value memories, valid bits, match tracking and result register.
`default_nettype none
module fte_datapath
  import fte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts
);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];

  in_item_t          req_r;
  logic [CAPACITY-1:0] valid_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              cmp_en_r;
  logic [KEY_W-1:0]  key_rd_r;
  logic [VAL_W-1:0]  val_rd_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [VAL_W-1:0]  hit_val_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [KEY_W-1:0]  req_key;
  logic              key_match;
  logic              key_we;
  logic              val_we;
  logic [IDX_W-1:0]  wr_idx;
  logic              set_valid;
  logic              clr_valid;
  out_item_t         res;

  assign req_key   = {req_r.source_address, req_r.dest_address,
                      req_r.source_port_in, req_r.dest_port_in};
  assign key_match = valid_r[rd_idx_r] && (key_rd_r == req_key);

  assign sts.scan_last = (idx_r == IDX_W'(CAPACITY - 1));
  assign sts.out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= req_key;
    end
    if (cmd.scan) begin
      key_rd_r <= key_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_idx] <= {req_r.flow_state_in, req_r.stamp_in, req_r.count_in};
    end
    if (cmd.scan) begin
      val_rd_r <= val_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.start) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmp_en_r) begin
        if (key_match && !hit_r) hit_r <= 1'b1;
        if (!valid_r[rd_idx_r] && !free_r) free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.scan) begin
      rd_idx_r <= idx_r;
    end
    if (cmp_en_r && key_match && !hit_r) begin
      hit_idx_r <= rd_idx_r;
      hit_val_r <= val_rd_r;
    end
    if (cmp_en_r && !valid_r[rd_idx_r] && !free_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    wr_idx    = hit_idx_r;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    res       = '0;
    res.status = ST_MISS;
    case (req_r.operation)
      OP_INSERT: begin
        if (hit_r) begin
          val_we     = cmd.commit;
          res.status = ST_HIT;
        end else if (free_r) begin
          wr_idx     = free_idx_r;
          key_we     = cmd.commit;
          val_we     = cmd.commit;
          set_valid  = cmd.commit;
          res.status = ST_NEW;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_LOOKUP, OP_REMOVE: begin
        if (hit_r) begin
          res.status         = ST_HIT;
          res.flow_state_out = hit_val_r[191:128];
          res.stamp_out      = hit_val_r[127:64];
          res.count_out      = hit_val_r[63:0];
          clr_valid          = cmd.commit && (req_r.operation == OP_REMOVE);
        end
      end
      default: begin
        res.status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (set_valid) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (clr_valid) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

/* hdl/fte_checker.sv */
// Port level checks of the flow table and the bind that attaches them.
`default_nettype none
module fte_checker
  import fte_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Item accepted while a previous item was still being processed.");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without an item in progress.");

  a_zero_values_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_HIT) |->
      (out_item.flow_state_out == 64'd0) && (out_item.stamp_out == 64'd0) &&
      (out_item.count_out == 64'd0))
    else $error("Nonzero value words on a result that is not a hit.");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result changed or was dropped.");

endmodule

bind flow_table_exact_match_unit fte_checker u_fte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
